// File: sv/rvg_pkg.sv
// ----------------------------------------------------------------------------
// rvg_pkg
// Shared constants, types and helpers for the voxel grid ray walker.
// ----------------------------------------------------------------------------
package rvg_pkg;

  localparam int GRID_X     = 16;
  localparam int GRID_Y     = 16;
  localparam int GRID_Z     = 16;
  localparam int RESULT_CAP = GRID_X + GRID_Y + GRID_Z - 2;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  localparam int IDX_W  = 6;   // cell coordinate, signed, holds -1 .. GRID
  localparam int CELL_W = 12;
  localparam int LIN_W  = 16;
  localparam int CRD_W  = 40;  // box coordinates, widened for GRID * cell_size
  localparam int NUM_W  = 56;  // dividend: CRD_W plus 16 fraction bits
  localparam int DEN_W  = 32;
  localparam int T_W    = 64;

  localparam logic signed [31:0]    NUDGE_Q32 = 32'sd4294967;  // 0.001 in Q0.32
  localparam logic signed [31:0]    T_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [31:0]    T_MIN     = 32'sh80000000;
  localparam logic signed [T_W-1:0] T_FAR     = 64'sh4000000000000000;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X,
    REG_BOX_MIN_Y,
    REG_BOX_MIN_Z,
    REG_CELL_SIZE_X,
    REG_CELL_SIZE_Y,
    REG_CELL_SIZE_Z
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIV_T1,
    DIV_T2,
    DIV_IDX,
    DIV_TM,
    DIV_TD
  } div_sel_t;

  typedef enum logic [1:0] {
    MUL_T,
    MUL_NUDGE,
    MUL_BOUND
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T1_GO,
    S_T1_WAIT,
    S_T2_GO,
    S_T2_WAIT,
    S_SLAB_UPD,
    S_SLAB_END,
    S_MISS,
    S_MUL_T,
    S_PN,
    S_MUL_N,
    S_REL,
    S_IDX_GO,
    S_IDX_WAIT,
    S_MUL_B,
    S_TM_GO,
    S_TM_WAIT,
    S_TD_GO,
    S_TD_WAIT,
    S_AXIS_END,
    S_WALK
  } state_t;

  typedef struct packed {
    logic [2:0][31:0] box_min;
    logic [2:0][30:0] cell_size;
  } rvg_cfg_t;

  typedef struct packed {
    logic     load;
    logic     axis_clr;
    logic     axis_inc;
    logic     div_start;
    logic     div_take;
    div_sel_t div_sel;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     slab_upd;
    logic     pn_ld;
    logic     rel_ld;
    logic     zero_step;
    logic     walk_step;
    logic     emit_miss;
  } rvg_cmd_t;

  typedef struct packed {
    logic dir_zero;
    logic axis_last;
    logic miss;
    logic div_done;
    logic walk_last;
  } rvg_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [T_W-1:0] v);
    logic signed [31:0] r;
    r = (v > T_W'(T_MAX)) ? T_MAX : (v < T_W'(T_MIN)) ? T_MIN : v[31:0];
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] grid_dim(input logic [1:0] ax);
    logic [IDX_W-1:0] g;
    case (ax)
      2'd0:    g = IDX_W'(GRID_X);
      2'd1:    g = IDX_W'(GRID_Y);
      default: g = IDX_W'(GRID_Z);
    endcase
    return g;
  endfunction

endpackage

// File: sv/ray_voxel_grid_traversal.sv
// ----------------------------------------------------------------------------
// ray_voxel_grid_traversal
// Slab box test and 3D DDA walk of one ray through a uniform voxel grid.
// Setup is paced by the one shared bit-serial divider (up to 15 quotients);
// less on an early miss or a zero direction component. Walk: one cell request
// per cycle, up to 46.
// A new ray is taken once busy drops, so one ray is in flight at a time.
// Synchronous reset: idle, box_min 0, cell sizes 1.0; results cannot stall.
// ----------------------------------------------------------------------------
module ray_voxel_grid_traversal (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic signed [31:0]          origin_z,
  input  logic signed [31:0]          dir_x,
  input  logic signed [31:0]          dir_y,
  input  logic signed [31:0]          dir_z,
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic                        result_strobe,
  output logic                        hit,
  output logic [rvg_pkg::CELL_W-1:0]  cell_index,
  output logic                        last_cell
);
  import rvg_pkg::*;

  rvg_cfg_t  cfg;
  rvg_cmd_t  cmd;
  rvg_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_min   <= '0;
      cfg.cell_size <= {3{31'd65536}};
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOX_MIN_X:   cfg.box_min[0]   <= cfg_data;
        REG_BOX_MIN_Y:   cfg.box_min[1]   <= cfg_data;
        REG_BOX_MIN_Z:   cfg.box_min[2]   <= cfg_data;
        REG_CELL_SIZE_X: cfg.cell_size[0] <= cfg_data[30:0];
        REG_CELL_SIZE_Y: cfg.cell_size[1] <= cfg_data[30:0];
        REG_CELL_SIZE_Z: cfg.cell_size[2] <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rvg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rvg_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .origin_z      (origin_z),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .hit           (hit),
    .cell_index    (cell_index),
    .last_cell     (last_cell)
  );

endmodule

// File: sv/rvg_div.sv
// ----------------------------------------------------------------------------
// rvg_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module rvg_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [rvg_pkg::NUM_W-1:0]   num,
  input  logic signed [rvg_pkg::DEN_W-1:0]   den,
  output logic                               done,
  output logic signed [rvg_pkg::NUM_W-1:0]   quot
);
  import rvg_pkg::*;

  localparam int DC_W = $clog2(NUM_W);

  logic             running;
  logic [DC_W-1:0]  cnt;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dmag;
  logic             neg;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_nx;
  logic             fits;

  always_comb begin
    rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};
    fits   = rem_sh >= {1'b0, dmag};
    rem_nx = fits ? rem_sh - {1'b0, dmag} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DC_W'(NUM_W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem  <= '0;
      neg  <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (running) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= rem_nx;
    end
  end

  assign quot = neg ? -signed'(quo) : signed'(quo);

endmodule

// File: sv/rvg_datapath.sv
// ----------------------------------------------------------------------------
// rvg_datapath
// Slab test, entry cell setup and the DDA walk registers for one ray.
// ----------------------------------------------------------------------------
module rvg_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rvg_pkg::rvg_cfg_t             cfg,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic signed [31:0]            origin_z,
  input  logic signed [31:0]            dir_x,
  input  logic signed [31:0]            dir_y,
  input  logic signed [31:0]            dir_z,
  input  rvg_pkg::rvg_cmd_t             cmd,
  output rvg_pkg::rvg_stat_t            stat,
  output logic                          result_strobe,
  output logic                          hit,
  output logic [rvg_pkg::CELL_W-1:0]    cell_index,
  output logic                          last_cell
);
  import rvg_pkg::*;

  // ray and per-axis state
  logic signed [31:0]       org [3];
  logic signed [31:0]       dir [3];
  logic [1:0]               ax;
  logic signed [T_W-1:0]    tn;
  logic signed [T_W-1:0]    tf;
  logic signed [T_W-1:0]    t1;
  logic signed [T_W-1:0]    t2;
  logic                     miss;
  logic signed [63:0]       prod;
  logic signed [CRD_W-1:0]  pn;
  logic signed [CRD_W-1:0]  rel;
  logic signed [IDX_W-1:0]  idx [3];
  logic signed [31:0]       nbt [3];
  logic signed [31:0]       bst [3];
  logic [CNT_W-1:0]         cnt;

  // per-axis selection
  logic signed [31:0]       org_a;
  logic signed [31:0]       dir_a;
  logic signed [31:0]       bmin_a;
  logic [30:0]              cs_a;
  logic [IDX_W-1:0]         gdim_a;
  logic [CRD_W-1:0]         span_a;
  logic signed [CRD_W-1:0]  bmax_a;
  logic signed [CRD_W-1:0]  bound_a;

  // divider
  logic signed [CRD_W-1:0]  diff;
  logic signed [NUM_W-1:0]  num;
  logic signed [DEN_W-1:0]  den;
  logic                     div_done;
  logic signed [NUM_W-1:0]  quot;
  logic signed [NUM_W-1:0]  quot_abs;
  logic [IDX_W-1:0]         idx_top;

  // multiplier
  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;

  // slab and entry point
  logic signed [T_W-1:0]    lo;
  logic signed [T_W-1:0]    hi;
  logic signed [T_W-1:0]    tn_n;
  logic signed [T_W-1:0]    tf_n;
  logic                     zero_out;
  logic signed [T_W-1:0]    pn_wide;
  logic signed [CRD_W-1:0]  pn_c;

  // walk
  logic [1:0]               wax;
  logic signed [IDX_W-1:0]  idx_n [3];
  logic signed [IDX_W-1:0]  lim [3];
  logic signed [32:0]       nsum;
  logic                     walk_last;
  logic [LIN_W-1:0]         lin;

  always_comb begin
    org_a   = org[ax];
    dir_a   = dir[ax];
    bmin_a  = signed'(cfg.box_min[ax]);
    cs_a    = (cfg.cell_size[ax] == '0) ? 31'd1 : cfg.cell_size[ax];
    gdim_a  = grid_dim(ax);
    span_a  = CRD_W'(cs_a) * CRD_W'(gdim_a);
    bmax_a  = CRD_W'(bmin_a) + signed'(span_a);
    bound_a = CRD_W'(bmin_a) + signed'(prod[CRD_W-1:0]);
  end

  always_comb begin
    diff = '0;
    den  = dir_a;
    unique case (cmd.div_sel)
      DIV_T1:  diff = CRD_W'(bmin_a) - CRD_W'(org_a);
      DIV_T2:  diff = bmax_a - CRD_W'(org_a);
      DIV_IDX: begin
        diff = rel;
        den  = signed'({1'b0, cs_a});
      end
      DIV_TM:  diff = bound_a - pn;
      DIV_TD:  diff = signed'(CRD_W'(cs_a));
      default: diff = '0;
    endcase
    num = (cmd.div_sel == DIV_IDX) ? NUM_W'(diff) : (NUM_W'(diff) <<< 16);
  end

  rvg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  assign quot_abs = quot[NUM_W-1] ? -quot : quot;
  assign idx_top  = gdim_a - 1'b1;

  always_comb begin
    mul_a = dir_a;
    mul_b = NUDGE_Q32;
    unique case (cmd.mul_sel)
      MUL_T:     mul_b = sat32(tn);
      MUL_NUDGE: mul_b = NUDGE_Q32;
      MUL_BOUND: begin
        mul_a = signed'({1'b0, cs_a});
        mul_b = 32'(idx[ax]) + (dir_a[31] ? 32'sd0 : 32'sd1);
      end
      default:   mul_b = NUDGE_Q32;
    endcase
  end

  always_comb begin
    lo       = (t1 > t2) ? t2 : t1;
    hi       = (t1 > t2) ? t1 : t2;
    tn_n     = (lo > tn) ? lo : tn;
    tf_n     = (hi < tf) ? hi : tf;
    zero_out = (CRD_W'(org_a) < CRD_W'(bmin_a)) || (CRD_W'(org_a) > bmax_a);
    pn_wide  = T_W'(org_a) + (prod >>> 16);
    if (pn_wide < T_W'(bmin_a)) begin
      pn_c = CRD_W'(bmin_a);
    end else if (pn_wide > T_W'(bmax_a)) begin
      pn_c = bmax_a;
    end else begin
      pn_c = pn_wide[CRD_W-1:0];
    end
  end

  // walk step: x only when strictly below y and z, then y strictly below z
  always_comb begin
    if (nbt[0] < nbt[1]) begin
      wax = (nbt[0] < nbt[2]) ? 2'd0 : 2'd2;
    end else begin
      wax = (nbt[1] < nbt[2]) ? 2'd1 : 2'd2;
    end
    for (int i = 0; i < 3; i++) begin
      lim[i]    = dir[i][31] ? -IDX_W'(1) : signed'(grid_dim(2'(i)));
      idx_n[i]  = idx[i];
      if (wax == 2'(i)) begin
        idx_n[i] = dir[i][31] ? idx[i] - IDX_W'(1) : idx[i] + IDX_W'(1);
      end
    end
    nsum      = 33'(nbt[wax]) + 33'(bst[wax]);
    walk_last = (idx_n[0] == lim[0]) || (idx_n[1] == lim[1]) || (idx_n[2] == lim[2])
             || ((CNT_W + 1)'(cnt) + 1'b1 >= (CNT_W + 1)'(RESULT_CAP));
    lin = LIN_W'(unsigned'(idx[0]))
        + LIN_W'(unsigned'(idx[1])) * LIN_W'(GRID_X)
        + LIN_W'(unsigned'(idx[2])) * LIN_W'(GRID_X * GRID_Y);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      org[0] <= origin_x;
      org[1] <= origin_y;
      org[2] <= origin_z;
      dir[0] <= dir_x;
      dir[1] <= dir_y;
      dir[2] <= dir_z;
      tn     <= -T_FAR;
      tf     <= T_FAR;
      miss   <= 1'b0;
      cnt    <= '0;
    end
    if (cmd.load || cmd.axis_clr) begin
      ax <= 2'd0;
    end else if (cmd.axis_inc) begin
      ax <= ax + 2'd1;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.slab_upd) begin
      if (dir_a == '0) begin
        miss <= miss | zero_out;
      end else begin
        tn   <= tn_n;
        tf   <= tf_n;
        miss <= miss | (tn_n > tf_n) | (tf_n < 0);
      end
    end
    if (cmd.pn_ld) begin
      pn <= pn_c;
    end
    if (cmd.rel_ld) begin
      rel <= pn + CRD_W'(prod >>> 32) - CRD_W'(bmin_a);
    end
    if (cmd.div_take && div_done) begin
      unique case (cmd.div_sel)
        DIV_T1:  t1 <= T_W'(quot);
        DIV_T2:  t2 <= T_W'(quot);
        DIV_IDX: begin
          if (rel[CRD_W-1]) begin
            idx[ax] <= '0;
          end else if (quot > signed'(NUM_W'(idx_top))) begin
            idx[ax] <= signed'(idx_top);
          end else begin
            idx[ax] <= signed'(quot[IDX_W-1:0]);
          end
        end
        DIV_TM:  nbt[ax] <= sat32(T_W'(quot));
        DIV_TD:  bst[ax] <= sat32(T_W'(quot_abs));
        default: ;
      endcase
    end
    if (cmd.zero_step) begin
      nbt[ax] <= T_MAX;
      bst[ax] <= '0;
    end
    if (cmd.walk_step) begin
      for (int i = 0; i < 3; i++) begin
        idx[i] <= idx_n[i];
      end
      nbt[wax] <= (nsum > 33'(T_MAX)) ? T_MAX : nsum[31:0];
      cnt      <= cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.walk_step | cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_miss) begin
      hit        <= 1'b0;
      cell_index <= '0;
      last_cell  <= 1'b1;
    end else if (cmd.walk_step) begin
      hit        <= 1'b1;
      cell_index <= lin[CELL_W-1:0];
      last_cell  <= walk_last;
    end
  end

  always_comb begin
    stat.dir_zero  = (dir_a == '0);
    stat.axis_last = (ax == 2'd2);
    stat.miss      = miss;
    stat.div_done  = div_done;
    stat.walk_last = walk_last;
  end

endmodule

// File: sv/rvg_ctrl.sv
// ----------------------------------------------------------------------------
// rvg_ctrl
// Sequencer: slab test per axis, then a miss result or entry setup per axis and the walk.
// ----------------------------------------------------------------------------
module rvg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rvg_pkg::rvg_stat_t  stat,
  output rvg_pkg::rvg_cmd_t   cmd,
  output logic                busy
);
  import rvg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (start) state_next = S_T1_GO;
      S_T1_GO: begin
        priority if (stat.miss)     state_next = S_MISS;
        else if (stat.dir_zero)     state_next = S_SLAB_UPD;
        else                        state_next = S_T1_WAIT;
      end
      S_T1_WAIT:  if (stat.div_done) state_next = S_T2_GO;
      S_T2_GO:    state_next = S_T2_WAIT;
      S_T2_WAIT:  if (stat.div_done) state_next = S_SLAB_UPD;
      S_SLAB_UPD: state_next = stat.axis_last ? S_SLAB_END : S_T1_GO;
      S_SLAB_END: state_next = stat.miss ? S_MISS : S_MUL_T;
      S_MISS:     state_next = S_IDLE;
      S_MUL_T:    state_next = S_PN;
      S_PN:       state_next = S_MUL_N;
      S_MUL_N:    state_next = S_REL;
      S_REL:      state_next = S_IDX_GO;
      S_IDX_GO:   state_next = S_IDX_WAIT;
      S_IDX_WAIT: if (stat.div_done) state_next = S_MUL_B;
      S_MUL_B:    state_next = S_TM_GO;
      S_TM_GO:    state_next = stat.dir_zero ? S_AXIS_END : S_TM_WAIT;
      S_TM_WAIT:  if (stat.div_done) state_next = S_TD_GO;
      S_TD_GO:    state_next = S_TD_WAIT;
      S_TD_WAIT:  if (stat.div_done) state_next = S_AXIS_END;
      S_AXIS_END: state_next = stat.axis_last ? S_WALK : S_MUL_T;
      S_WALK:     if (stat.walk_last) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_T1;
    cmd.mul_sel = MUL_T;
    unique case (state)
      S_IDLE:     cmd.load = start;
      S_T1_GO:    cmd.div_start = !stat.miss && !stat.dir_zero;
      S_T1_WAIT:  cmd.div_take = 1'b1;
      S_T2_GO: begin
        cmd.div_sel   = DIV_T2;
        cmd.div_start = 1'b1;
      end
      S_T2_WAIT: begin
        cmd.div_sel  = DIV_T2;
        cmd.div_take = 1'b1;
      end
      S_SLAB_UPD: begin
        cmd.slab_upd = 1'b1;
        cmd.axis_inc = !stat.axis_last;
      end
      S_SLAB_END: cmd.axis_clr = 1'b1;
      S_MISS:     cmd.emit_miss = 1'b1;
      S_MUL_T:    cmd.mul_en = 1'b1;
      S_PN:       cmd.pn_ld = 1'b1;
      S_MUL_N: begin
        cmd.mul_sel = MUL_NUDGE;
        cmd.mul_en  = 1'b1;
      end
      S_REL:      cmd.rel_ld = 1'b1;
      S_IDX_GO: begin
        cmd.div_sel   = DIV_IDX;
        cmd.div_start = 1'b1;
      end
      S_IDX_WAIT: begin
        cmd.div_sel  = DIV_IDX;
        cmd.div_take = 1'b1;
      end
      S_MUL_B: begin
        cmd.mul_sel = MUL_BOUND;
        cmd.mul_en  = 1'b1;
      end
      S_TM_GO: begin
        cmd.div_sel   = DIV_TM;
        cmd.div_start = !stat.dir_zero;
        cmd.zero_step = stat.dir_zero;
      end
      S_TM_WAIT: begin
        cmd.div_sel  = DIV_TM;
        cmd.div_take = 1'b1;
      end
      S_TD_GO: begin
        cmd.div_sel   = DIV_TD;
        cmd.div_start = 1'b1;
      end
      S_TD_WAIT: begin
        cmd.div_sel  = DIV_TD;
        cmd.div_take = 1'b1;
      end
      S_AXIS_END: cmd.axis_inc = !stat.axis_last;
      S_WALK:     cmd.walk_step = 1'b1;
      default:    cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: sv/rvg_checker.sv
// ----------------------------------------------------------------------------
// rvg_checker
// Port-level checks on request acceptance and the result run.
// ----------------------------------------------------------------------------
module rvg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_strobe,
  input logic                        hit,
  input logic [rvg_pkg::CELL_W-1:0]  cell_index,
  input logic                        last_cell
);

  // an accepted request starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // a walk delivers its cells without gaps until the last one
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_cell |=> result_strobe)
    else $error("gap in result run");

  // a miss is a single closing result with index zero
  a_miss_form: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !hit |-> last_cell && (cell_index == '0))
    else $error("malformed miss result");

  // no result appears out of an idle cycle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !result_strobe)
    else $error("result without a request");

endmodule

bind ray_voxel_grid_traversal rvg_checker u_rvg_checker (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_voxel_grid_traversal: rays are sent through the
// command port, and every result is checked against an in-bench slab and DDA
// walk predictor. The grid box is changed between phases through the register
// write port, including extreme corners and cell sizes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rvg_pkg::*;

  localparam longint TIMEOUT_CYCLES = 2000000;
  localparam longint T_START        = 64'sh4000000000000000;

  typedef struct {
    bit        hit;
    bit [11:0] cidx;
    bit        last;
  } cell_req_t;

  class walk_scoreboard;
    longint    bmin[3];
    longint    csz[3];
    cell_req_t pending[$];
    int        errors;
    int        rays;
    int        hits;
    int        cells;

    function new();
      for (int i = 0; i < 3; i++) begin
        bmin[i] = 0;
        csz[i]  = 65536;
      end
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      if (r <= REG_BOX_MIN_Z) bmin[int'(r)] = longint'(signed'(v));
      else csz[int'(r) - 3] = longint'(v[30:0]);
    endfunction

    function longint clip32(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function void add_expected(cell_req_t e);
      pending.insert(pending.size(), e);
    endfunction

    // expected cell requests for one ray
    function void note_ray(logic signed [31:0] o[3], logic signed [31:0] d[3]);
      longint org[3], dr[3], cs[3], bmax[3], pn[3], lim[3], idx[3];
      longint tn, tf, t1, t2, sw, rel, bound, q;
      int     nb[3], st[3];
      bit     neg[3];
      bit     miss;
      int     n, ax;
      cell_req_t e;
      tn = -T_START;
      tf = T_START;
      miss = 0;
      n = 0;
      rays++;
      for (int i = 0; i < 3; i++) begin
        org[i]  = longint'(o[i]);
        dr[i]   = longint'(d[i]);
        cs[i]   = (csz[i] != 0) ? csz[i] : 1;
        bmax[i] = bmin[i] + 16 * cs[i];
      end
      for (int i = 0; i < 3 && !miss; i++) begin
        if (dr[i] == 0) begin
          if (org[i] < bmin[i] || org[i] > bmax[i]) miss = 1;
        end else begin
          t1 = ((bmin[i] - org[i]) * 65536) / dr[i];
          t2 = ((bmax[i] - org[i]) * 65536) / dr[i];
          if (t1 > t2) begin
            sw = t1; t1 = t2; t2 = sw;
          end
          if (t1 > tn) tn = t1;
          if (t2 < tf) tf = t2;
          if (tn > tf || tf < 0) miss = 1;
        end
      end
      if (miss) begin
        e.hit = 0; e.cidx = 0; e.last = 1;
        add_expected(e);
        return;
      end
      hits++;
      for (int i = 0; i < 3; i++) begin
        pn[i] = org[i];
        if (dr[i] != 0) pn[i] += (dr[i] * clip32(tn)) >>> 16;
        if (pn[i] < bmin[i]) pn[i] = bmin[i];
        if (pn[i] > bmax[i]) pn[i] = bmax[i];
        rel = pn[i] + ((dr[i] * 4294967) >>> 32) - bmin[i];
        if (rel < 0) idx[i] = 0;
        else begin
          q = rel / cs[i];
          idx[i] = (q > 15) ? 15 : q;
        end
        neg[i] = dr[i] < 0;
        lim[i] = neg[i] ? -1 : 16;
        if (dr[i] == 0) begin
          nb[i] = 32'h7FFFFFFF;
          st[i] = 0;
        end else begin
          bound = bmin[i] + (idx[i] + (neg[i] ? 0 : 1)) * cs[i];
          nb[i] = int'(clip32(((bound - pn[i]) * 65536) / dr[i]));
          st[i] = int'(clip32((cs[i] * 65536) / (neg[i] ? -dr[i] : dr[i])));
        end
      end
      forever begin
        e.hit  = 1;
        e.cidx = 12'(idx[0] + idx[1] * 16 + idx[2] * 256);
        e.last = 0;
        add_expected(e);
        n++;
        // ties go to the later axis
        if (nb[0] < nb[1]) ax = (nb[0] < nb[2]) ? 0 : 2;
        else ax = (nb[1] < nb[2]) ? 1 : 2;
        idx[ax] += neg[ax] ? -1 : 1;
        nb[ax] = int'(clip32(longint'(nb[ax]) + st[ax]));
        if (idx[0] == lim[0] || idx[1] == lim[1] || idx[2] == lim[2] || n >= RESULT_CAP)
          break;
      end
      pending[$].last = 1;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_req(bit h, bit [11:0] c, bit l);
      cell_req_t e;
      cells++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected request hit=%0b cell=%0d last=%0b", h, c, l));
        return;
      end
      e = pending.pop_front();
      if (h !== e.hit || c !== e.cidx || l !== e.last)
        report_mismatch($sformatf("got hit=%0b cell=%0d last=%0b, want %0b %0d %0b",
                                  h, c, l, e.hit, e.cidx, e.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic cfg_write = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic result_strobe, hit, last_cell;
  logic [CELL_W-1:0] cell_index;
  longint cycles = 0;

  walk_scoreboard sb = new();

  ray_voxel_grid_traversal u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_strobe === 1'b1) sb.check_req(hit, cell_index, last_cell);
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout with %0d requests outstanding", sb.pending.size());
      $display("FAIL ray_voxel_grid_traversal");
      $finish;
    end
  end

  task send_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    logic signed [31:0] o[3], d[3];
    o = '{ox, oy, oz};
    d = '{dx, dy, dz};
    start <= 1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    do @(posedge clk); while (busy);
    sb.note_ray(o, d);
  endtask

  task pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task drain();
    pause(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task write_reg(reg_idx_t r, logic [31:0] v);
    cfg_write <= 1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(r, v);
  endtask

  task set_box(logic [31:0] bx, by, bz, cx, cy, cz);
    drain();
    write_reg(REG_BOX_MIN_X, bx);
    write_reg(REG_BOX_MIN_Y, by);
    write_reg(REG_BOX_MIN_Z, bz);
    write_reg(REG_CELL_SIZE_X, cx);
    write_reg(REG_CELL_SIZE_Y, cy);
    write_reg(REG_CELL_SIZE_Z, cz);
    cfg_write <= 0;
  endtask

  function automatic logic signed [31:0] rand_dir();
    logic signed [31:0] m;
    case ($urandom_range(0, 9))
      0:       m = 0;
      1:       m = $urandom;
      2:       m = $urandom_range(1, 255);
      default: m = $urandom_range(1, 32'h0004_0000);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // aims at a random point in the box, starting at it or some distance back along the ray
  task aimed_ray(bit gaps);
    logic signed [31:0] o[3], d[3];
    longint tgt, back;
    back = $urandom_range(0, 1) ? 0 : longint'($urandom_range(0, 32'h0010_0000));
    for (int i = 0; i < 3; i++) begin
      d[i] = rand_dir();
      tgt  = sb.bmin[i] + longint'($urandom) % (16 * ((sb.csz[i] != 0) ? sb.csz[i] : 1) + 1);
      o[i] = 32'(sb.clip32(tgt - ((longint'(d[i]) * back) >>> 16)));
    end
    if ($urandom_range(0, 9) == 0) o[$urandom_range(0, 2)] = $urandom;
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    if (gaps && $urandom_range(0, 2) == 0) pause($urandom_range(1, 13));
  endtask

  task random_phase(int n, bit gaps);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else aimed_ray(gaps);
    end
  endtask

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MID = 32'sh0008_8000;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: axis walks both ways, zero direction, diagonal ties, misses
    send_ray(-ONE, MID, MID, ONE, 0, 0);
    send_ray(32'sh0011_0000, MID, MID, -ONE, 0, 0);
    send_ray(MID, -ONE, MID, 0, ONE, 0);
    send_ray(MID, 32'sh0011_0000, MID, 0, -ONE, 0);
    send_ray(MID, MID, -ONE, 0, 0, ONE);
    send_ray(MID, MID, 32'sh0011_0000, 0, 0, -ONE);
    send_ray(MID, MID, MID, 0, 0, 0);
    send_ray(32'sh0020_0000, MID, MID, 0, 0, 0);
    send_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray(0, 0, 0, ONE, ONE, ONE);
    send_ray(32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000, -ONE, -ONE, -ONE);
    send_ray(-ONE, MID, MID, -ONE, 0, 0);
    send_ray(-ONE, -ONE, MID, ONE, 32'sh0000_4000, 0);
    send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000);
    send_ray(MID, MID, MID, 1, -1, 32'sh7FFF_FFFF);
    send_ray(32'hFFFF_FFFF, 0, 0, 32'sh8000_0000, 1, 1);
    pause(3);
    random_phase(50, 1);

    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF);
    send_ray(0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    random_phase(40, 1);

    set_box(32'h7FFF_FFFF, 32'hFFF8_0000, 32'h0000_0003, 1, 32'h0000_8000, 32'h0003_0000);
    send_ray(32'sh7FFF_FFFF, 32'shFFF8_0000, 3, 1, 1, 1);
    random_phase(40, 1);

    set_box(32'hFFFE_0000, 32'h0001_2345, 32'hC000_0000, 32'h0000_4000, 32'h0002_0000,
            32'h1000_0000);
    random_phase(40, 1);

    set_box(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    random_phase(50, 1);
    // last stretch back to back, no gaps
    random_phase(40, 0);

    drain();
    $display("%0d rays (%0d hitting the box), %0d cell requests checked over 5 box setups",
             sb.rays, sb.hits, sb.cells);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS ray_voxel_grid_traversal");
    else $display("FAIL ray_voxel_grid_traversal");
    $finish;
  end
endmodule
